/* hdl/cbd_pkg.sv */
package cbd_pkg;

	localparam int COORD_W    = 24;
	localparam int RADIUS_W   = 14;
	localparam int FACTOR_W   = 11;
	localparam int DIST_W     = 16;
	localparam int SQ_IN_W    = 2 * DIST_W;
	localparam int MAG_W      = COORD_W + 1;
	localparam int RSUM_W     = RADIUS_W + 1;
	localparam int MUL_W      = 26;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int D2_W       = 50;
	localparam int FRAC_SHIFT = 20;
	localparam int ATOM_W     = 3 * COORD_W + RADIUS_W;
	localparam int IN_TDATA_W = ((ATOM_W + 7) / 8) * 8;

	localparam logic [FACTOR_W-1:0] FACTOR_RESET = 11'd1229;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_DIFF,
		ST_MX,
		ST_MY,
		ST_MZ,
		ST_MT,
		ST_MP,
		ST_CMP,
		ST_SQRT,
		ST_PUSH,
		ST_NEXT,
		ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_DX,
		MUL_DY,
		MUL_DZ,
		MUL_T,
		MUL_P
	} mul_sel_t;

	// Magnitude of the difference of two signed coordinates.
	function automatic logic [MAG_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
		input logic [COORD_W-1:0] b);
		logic [MAG_W-1:0] d;
		d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		return d[MAG_W-1] ? (~d + 1'b1) : d;
	endfunction

endpackage

/* hdl/cbd_ram.sv */
module cbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hdl/cbd_isqrt.sv */
module cbd_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [cbd_pkg::SQ_IN_W-1:0]   operand,
	output logic [cbd_pkg::DIST_W-1:0]    root,
	output logic                          done
);

	import cbd_pkg::*;

	localparam int STEP_W = $clog2(DIST_W);

	logic [SQ_IN_W-1:0] rem_q;
	logic [SQ_IN_W-1:0] res_q;
	logic [SQ_IN_W-1:0] bit_q;
	logic [SQ_IN_W:0]   trial;
	logic [STEP_W-1:0]  step_q;
	logic               busy_q;
	logic               done_q;

	assign trial = {1'b0, res_q} + {1'b0, bit_q};
	assign root  = res_q[DIST_W-1:0];
	assign done  = done_q;

	// One result bit per cycle, two operand bits consumed per step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DIST_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= operand;
			res_q <= '0;
			bit_q <= SQ_IN_W'(1) << (SQ_IN_W - 2);
		end else if (busy_q) begin
			if ({1'b0, rem_q} >= trial) begin
				rem_q <= rem_q - trial[SQ_IN_W-1:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

/* hdl/covalent_bond_detector.sv */
// Channel  Direction  Handshake               Word
// s_       in         s_tvalid / s_tready     one atom
// m_       out        m_tvalid / m_tready     one bond or one flagged result
// cfg_     in         cfg_valid / cfg_ready   threshold factor
//
// Every earlier atom in the store is scanned in turn, and each bond found
// also passes through the square-root unit.
// Each earlier atom costs one registered read of the atom store and five
// passes through the one shared 26 x 26 multiplier.
// Reset clears the atom count and sets the factor to 1229; the store itself
// is not cleared. A stalled m_ channel holds the scan where it is.
module covalent_bond_detector #(
	parameter int MAX_ATOMS = 64,
	localparam int IDX_W = $clog2(MAX_ATOMS),
	localparam int OUT_W = ((2 * IDX_W + cbd_pkg::DIST_W + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// pos_x, pos_y, pos_z, radius
	input  logic [cbd_pkg::IN_TDATA_W-1:0]  s_tdata,
	// start_molecule
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// atom_index, partner_index, distance
	output logic [OUT_W-1:0]                m_tdata,
	// bonded, store_full
	output logic [1:0]                      m_tuser,
	output logic                            m_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cbd_pkg::FACTOR_W-1:0]    cfg_data
);

	import cbd_pkg::*;

	localparam int CNT_W = $clog2(MAX_ATOMS + 1);

	state_t state_q, state_d;

	logic [CNT_W-1:0]    count_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    scan_q;
	logic                full_q;
	logic [FACTOR_W-1:0] factor_q;

	logic [COORD_W-1:0]  atom_x_q, atom_y_q, atom_z_q;
	logic [RADIUS_W-1:0] atom_r_q;
	logic [MAG_W-1:0]    dx_q, dy_q, dz_q;
	logic [RSUM_W-1:0]   rsum_q;
	logic [PROD_W-1:0]   prod_q;
	logic [D2_W-1:0]     d2_q;

	logic                hold_valid_q;
	logic [IDX_W-1:0]    hold_partner_q;
	logic [DIST_W-1:0]   hold_dist_q;

	logic                out_valid_q;
	logic [IDX_W-1:0]    out_atom_q, out_partner_q;
	logic [DIST_W-1:0]   out_dist_q;
	logic                out_bonded_q, out_full_q, out_last_q;

	logic [ATOM_W-1:0]   rd_word;
	logic [COORD_W-1:0]  rd_x, rd_y, rd_z;
	logic [RADIUS_W-1:0] rd_r;

	logic                accept, out_free, in_full, last_scan, bond;
	logic [CNT_W-1:0]    in_cnt;
	logic [IDX_W-1:0]    in_idx;
	logic [31:0]         q_part;
	logic [FRAC_SHIFT-1:0] q_rem;

	mul_sel_t            mul_sel;
	logic [MUL_W-1:0]    mul_a, mul_b;
	logic                wr_en, d2_init, d2_acc, sqrt_start, hold_load, mid_load;
	logic                fin_load, scan_inc;
	logic                sqrt_done;
	logic [DIST_W-1:0]   sqrt_root;

	assign accept    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign in_cnt    = s_tuser ? '0 : count_q;
	assign in_idx    = in_cnt[IDX_W-1:0];
	assign in_full   = !s_tuser && (count_q == CNT_W'(MAX_ATOMS));
	assign last_scan = ({1'b0, scan_q} + 1'b1) == {1'b0, idx_q};

	assign rd_x = rd_word[COORD_W-1:0];
	assign rd_y = rd_word[2*COORD_W-1:COORD_W];
	assign rd_z = rd_word[3*COORD_W-1:2*COORD_W];
	assign rd_r = rd_word[ATOM_W-1:3*COORD_W];

	// Bonded when d2 * 2^20 < p, split into integer and fraction parts of p.
	assign q_part = prod_q[PROD_W-1:FRAC_SHIFT];
	assign q_rem  = prod_q[FRAC_SHIFT-1:0];
	assign bond   = (d2_q < D2_W'(q_part)) || (d2_q == D2_W'(q_part) && q_rem != '0);

	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = OUT_W'({out_dist_q, out_partner_q, out_atom_q});
	assign m_tuser   = {out_full_q, out_bonded_q};
	assign m_tlast   = out_last_q;

	cbd_ram #(
		.WIDTH(ATOM_W),
		.DEPTH(MAX_ATOMS)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(in_idx),
		.wdata(s_tdata[ATOM_W-1:0]),
		.raddr(scan_q),
		.rdata(rd_word)
	);

	cbd_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.operand(d2_q[SQ_IN_W-1:0]),
		.root   (sqrt_root),
		.done   (sqrt_done)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (in_full || in_cnt == '0) ? ST_FIN : ST_READ;
				end
			end
			ST_READ: state_d = ST_DIFF;
			ST_DIFF: state_d = ST_MX;
			ST_MX:   state_d = ST_MY;
			ST_MY:   state_d = ST_MZ;
			ST_MZ:   state_d = ST_MT;
			ST_MT:   state_d = ST_MP;
			ST_MP:   state_d = ST_CMP;
			ST_CMP:  state_d = bond ? ST_SQRT : ST_NEXT;
			ST_SQRT: begin
				if (sqrt_done) begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (!hold_valid_q || out_free) begin
					state_d = ST_NEXT;
				end
			end
			ST_NEXT: state_d = last_scan ? ST_FIN : ST_READ;
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = (state_q == ST_IDLE);
		wr_en      = 1'b0;
		mul_sel    = MUL_NONE;
		d2_init    = 1'b0;
		d2_acc     = 1'b0;
		sqrt_start = 1'b0;
		hold_load  = 1'b0;
		mid_load   = 1'b0;
		fin_load   = 1'b0;
		scan_inc   = 1'b0;
		case (state_q)
			ST_IDLE: wr_en = s_tvalid && !in_full;
			ST_MX:   mul_sel = MUL_DX;
			ST_MY: begin
				mul_sel = MUL_DY;
				d2_init = 1'b1;
			end
			ST_MZ: begin
				mul_sel = MUL_DZ;
				d2_acc  = 1'b1;
			end
			ST_MT: begin
				mul_sel = MUL_T;
				d2_acc  = 1'b1;
			end
			ST_MP:   mul_sel = MUL_P;
			ST_CMP:  sqrt_start = bond;
			ST_PUSH: begin
				hold_load = !hold_valid_q || out_free;
				mid_load  = hold_valid_q && out_free;
			end
			ST_NEXT: scan_inc = !last_scan;
			ST_FIN:  fin_load = out_free;
			default: ;
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (mul_sel)
			MUL_DX: begin
				mul_a = MUL_W'(dx_q);
				mul_b = MUL_W'(dx_q);
			end
			MUL_DY: begin
				mul_a = MUL_W'(dy_q);
				mul_b = MUL_W'(dy_q);
			end
			MUL_DZ: begin
				mul_a = MUL_W'(dz_q);
				mul_b = MUL_W'(dz_q);
			end
			MUL_T: begin
				mul_a = MUL_W'(factor_q);
				mul_b = MUL_W'(rsum_q);
			end
			MUL_P: begin
				mul_a = prod_q[MUL_W-1:0];
				mul_b = prod_q[MUL_W-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			factor_q     <= FACTOR_RESET;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				factor_q <= cfg_data;
			end
			if (accept) begin
				hold_valid_q <= 1'b0;
				if (!in_full) begin
					count_q <= in_cnt + 1'b1;
				end
			end else if (hold_load) begin
				hold_valid_q <= 1'b1;
			end
			if (mid_load || fin_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q    <= in_idx;
			full_q   <= in_full;
			scan_q   <= '0;
			atom_x_q <= s_tdata[COORD_W-1:0];
			atom_y_q <= s_tdata[2*COORD_W-1:COORD_W];
			atom_z_q <= s_tdata[3*COORD_W-1:2*COORD_W];
			atom_r_q <= s_tdata[ATOM_W-1:3*COORD_W];
		end else if (scan_inc) begin
			scan_q <= scan_q + 1'b1;
		end

		if (state_q == ST_DIFF) begin
			dx_q   <= abs_diff(atom_x_q, rd_x);
			dy_q   <= abs_diff(atom_y_q, rd_y);
			dz_q   <= abs_diff(atom_z_q, rd_z);
			rsum_q <= {1'b0, atom_r_q} + {1'b0, rd_r};
		end

		if (mul_sel != MUL_NONE) begin
			prod_q <= mul_a * mul_b;
		end

		// The square produced in the previous state is folded in here.
		if (d2_init) begin
			d2_q <= D2_W'(prod_q);
		end else if (d2_acc) begin
			d2_q <= d2_q + D2_W'(prod_q);
		end

		if (hold_load) begin
			hold_partner_q <= scan_q;
			hold_dist_q    <= sqrt_root;
		end

		if (mid_load) begin
			out_atom_q    <= idx_q;
			out_partner_q <= hold_partner_q;
			out_dist_q    <= hold_dist_q;
			out_bonded_q  <= 1'b1;
			out_full_q    <= 1'b0;
			out_last_q    <= 1'b0;
		end else if (fin_load) begin
			out_last_q <= 1'b1;
			if (full_q) begin
				out_atom_q    <= '0;
				out_partner_q <= '0;
				out_dist_q    <= '0;
				out_bonded_q  <= 1'b0;
				out_full_q    <= 1'b1;
			end else if (hold_valid_q) begin
				out_atom_q    <= idx_q;
				out_partner_q <= hold_partner_q;
				out_dist_q    <= hold_dist_q;
				out_bonded_q  <= 1'b1;
				out_full_q    <= 1'b0;
			end else begin
				out_atom_q    <= idx_q;
				out_partner_q <= '0;
				out_dist_q    <= '0;
				out_bonded_q  <= 1'b0;
				out_full_q    <= 1'b0;
			end
		end
	end

endmodule

/* test/covalent_bond_detector_tb.sv */
`timescale 1ns / 100ps

module covalent_bond_detector_tb;
	import cbd_pkg::*;

	localparam int ATOM_CAP      = 64;
	localparam int IDX_W         = $clog2(ATOM_CAP);
	localparam int OUT_W         = ((2 * IDX_W + DIST_W + 7) / 8) * 8;
	localparam int RESET_CYCLES  = 12;
	localparam int IDLE_PCT      = 9;
	localparam int SETTLE_CYCLES = 32;
	localparam int STALL_LIMIT   = 10000;
	localparam int REPORT_LIMIT  = 10;

	typedef struct packed {
		logic                start;
		logic [COORD_W-1:0]  x;
		logic [COORD_W-1:0]  y;
		logic [COORD_W-1:0]  z;
		logic [RADIUS_W-1:0] radius;
	} atom_t;

	typedef struct packed {
		logic [IDX_W-1:0]  atom_idx;
		logic [IDX_W-1:0]  partner_idx;
		logic [DIST_W-1:0] bond_len;
		logic              bonded;
		logic              full;
		logic              last;
	} bond_t;

	// Keeps its own copy of the atom store and the factor, and queues the
	// bond words that each accepted atom should produce.
	class bond_tracker;
		logic [COORD_W-1:0]  xs[ATOM_CAP];
		logic [COORD_W-1:0]  ys[ATOM_CAP];
		logic [COORD_W-1:0]  zs[ATOM_CAP];
		logic [RADIUS_W-1:0] rs[ATOM_CAP];
		int                  count;
		logic [FACTOR_W-1:0] factor;
		bond_t               due_words[$];
		int                  mismatches;

		function new();
			count = 0;
			factor = FACTOR_RESET;
			mismatches = 0;
		endfunction

		static function longint gap_sq(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
			longint d;
			d = longint'($signed(a)) - longint'($signed(b));
			return d * d;
		endfunction

		static function logic [DIST_W-1:0] floor_root(longint v);
			logic [DIST_W-1:0] r;
			longint c;
			r = '0;
			for (int b = DIST_W - 1; b >= 0; b--) begin
				c = longint'(r) | (longint'(1) << b);
				if (c * c <= v)
					r = DIST_W'(c);
			end
			return r;
		endfunction

		function void note_atom(atom_t a);
			bond_t  found[$];
			bond_t  r;
			longint d2;
			longint t;
			longint reach;
			if (a.start)
				count = 0;
			r = '0;
			if (count >= ATOM_CAP) begin
				r.full = 1'b1;
				r.last = 1'b1;
				due_words = {due_words, r};
				return;
			end
			for (int i = 0; i < count; i++) begin
				d2 = gap_sq(a.x, xs[i]) + gap_sq(a.y, ys[i]) + gap_sq(a.z, zs[i]);
				t = longint'(factor) * (longint'(a.radius) + longint'(rs[i]));
				// d2 * 2^20 < t^2 holds exactly when d2 is below t^2 / 2^20 rounded up.
				reach = (t * t + (longint'(1) << FRAC_SHIFT) - 1) >> FRAC_SHIFT;
				if (d2 < reach) begin
					r = '0;
					r.atom_idx = IDX_W'(count);
					r.partner_idx = IDX_W'(i);
					r.bond_len = floor_root(d2);
					r.bonded = 1'b1;
					found = {found, r};
				end
			end
			xs[count] = a.x;
			ys[count] = a.y;
			zs[count] = a.z;
			rs[count] = a.radius;
			r = '0;
			r.atom_idx = IDX_W'(count);
			r.last = 1'b1;
			count++;
			if (found.size() == 0) begin
				due_words = {due_words, r};
			end else begin
				found[found.size() - 1].last = 1'b1;
				foreach (found[k])
					due_words = {due_words, found[k]};
			end
		endfunction

		function void show(string tag, bond_t b);
			$display("  %s atom=%0d partner=%0d dist=%0d bonded=%0b full=%0b last=%0b",
				tag, b.atom_idx, b.partner_idx, b.bond_len, b.bonded, b.full, b.last);
		endfunction

		function void check_bond(bond_t seen);
			bond_t want;
			if (due_words.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("ERROR: word arrived with nothing outstanding at %0t", $time);
					show("actual  ", seen);
				end
				return;
			end
			want = due_words.pop_front();
			if (seen.atom_idx !== want.atom_idx || seen.partner_idx !== want.partner_idx ||
				seen.bond_len !== want.bond_len || seen.bonded !== want.bonded ||
				seen.full !== want.full || seen.last !== want.last) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("ERROR: bond word mismatch at %0t", $time);
					show("expected", want);
					show("actual  ", seen);
				end
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_W-1:0]      m_tdata;
	logic [1:0]            m_tuser;
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [FACTOR_W-1:0]   cfg_data = '0;

	logic                  steady = 1'b0;
	int                    quiet_cycles = 0;
	bond_tracker           tracker = new();

	covalent_bond_detector #(
		.MAX_ATOMS(ATOM_CAP)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	always @(negedge clk)
		m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_bond({m_tdata[IDX_W-1:0], m_tdata[2*IDX_W-1:IDX_W],
				m_tdata[2*IDX_W +: DIST_W], m_tuser[0], m_tuser[1], m_tlast});
	end

	// Ends the run if no word moves on any channel for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_atom(input atom_t a);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_TDATA_W'({a.radius, a.z, a.y, a.x});
		s_tuser  <= a.start;
		do @(posedge clk); while (!s_tready);
		tracker.note_atom(a);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (tracker.due_words.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_factor(input logic [FACTOR_W-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		tracker.factor = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic atom_t atom_at(logic start, int x, int y, int z, int r);
		atom_t a;
		a.start = start;
		a.x = COORD_W'(x);
		a.y = COORD_W'(y);
		a.z = COORD_W'(z);
		a.radius = RADIUS_W'(r);
		return a;
	endfunction

	function automatic logic [COORD_W-1:0] centre_coord();
		return COORD_W'($urandom_range(0, 16_000_000) - 32'd8_000_000);
	endfunction

	function automatic atom_t cluster_atom(logic start, logic [COORD_W-1:0] cx,
		logic [COORD_W-1:0] cy, logic [COORD_W-1:0] cz, int spread);
		atom_t a;
		a.start = start;
		a.x = cx + COORD_W'($urandom_range(0, 2 * spread) - spread);
		a.y = cy + COORD_W'($urandom_range(0, 2 * spread) - spread);
		a.z = cz + COORD_W'($urandom_range(0, 2 * spread) - spread);
		a.radius = ($urandom_range(9) == 0) ? RADIUS_W'($urandom) :
			RADIUS_W'($urandom_range(2500, 7000));
		return a;
	endfunction

	function automatic atom_t stray_atom(logic start);
		atom_t a;
		a.start = start;
		a.x = COORD_W'($urandom);
		a.y = COORD_W'($urandom);
		a.z = COORD_W'($urandom);
		a.radius = RADIUS_W'($urandom);
		return a;
	endfunction

	task automatic directed_atoms();
		// A short chain under the reset factor, then the coordinate extremes.
		send_atom(atom_at(1, 0, 0, 0, 3100));
		send_atom(atom_at(0, 6308, 0, 0, 3100));
		send_atom(atom_at(0, 0, 0, 0, 3100));
		send_atom(atom_at(0, -8388608, -8388608, -8388608, 16383));
		send_atom(atom_at(0, 8388607, 8388607, 8388607, 16383));
		send_atom(atom_at(0, 8388607, 8388607, 8388600, 16383));
		send_atom(atom_at(0, 3000, 2000, -1000, 0));
		// With a zero factor even coincident atoms do not bond.
		write_factor('0);
		send_atom(atom_at(1, 100, 100, 100, 16383));
		send_atom(atom_at(0, 100, 100, 100, 16383));
		// The largest factor and radii push the bond length towards the top of its field.
		write_factor('1);
		send_atom(atom_at(1, 0, 0, 0, 16383));
		send_atom(atom_at(0, 65000, 0, 0, 16383));
		send_atom(atom_at(0, 0, 0, 1, 0));
		send_atom(atom_at(0, -40000, -40000, 0, 16383));
		// Two zero radii give a zero threshold.
		write_factor(FACTOR_RESET);
		send_atom(atom_at(1, -5, 7, 9, 0));
		send_atom(atom_at(0, -5, 7, 9, 0));
	endtask

	// A tight cluster fills every slot, so the last atom bonds with nearly
	// all the others; the atoms after it find the store full.
	task automatic fill_store();
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		logic [COORD_W-1:0] cz;
		cx = centre_coord();
		cy = centre_coord();
		cz = centre_coord();
		for (int k = 0; k < ATOM_CAP; k++)
			send_atom(cluster_atom(k == 0, cx, cy, cz, 400));
		repeat ($urandom_range(1, 3))
			send_atom(stray_atom(1'b0));
	endtask

	// Mostly whole molecules around a random centre; now and then a stray atom
	// or a molecule whose opening atom lacks the start flag.
	task automatic random_molecules(input int n_atoms);
		int                 sent;
		int                 len;
		int                 spread;
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		logic [COORD_W-1:0] cz;
		sent = 0;
		while (sent < n_atoms) begin
			len = $urandom_range(1, 12);
			spread = $urandom_range(2000, 30000);
			cx = centre_coord();
			cy = centre_coord();
			cz = centre_coord();
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(99) < 10)
					send_atom(stray_atom($urandom_range(3) == 0));
				else
					send_atom(cluster_atom(k == 0 && $urandom_range(9) != 0, cx, cy, cz,
						spread));
				sent++;
			end
		end
	endtask

	initial begin
		logic [FACTOR_W-1:0] factor;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		directed_atoms();
		// The whole store fill runs with no idling on either side.
		steady = 1'b1;
		fill_store();
		steady = 1'b0;
		for (int p = 0; p < 4; p++) begin
			case ($urandom_range(3))
				0: factor = FACTOR_RESET;
				1: factor = 11'd1024;
				2: factor = 11'd1638;
				default: factor = FACTOR_W'($urandom);
			endcase
			write_factor(factor);
			steady = (p == 2);
			random_molecules(3);
		end
		wait_idle();
		steady = 1'b0;
		if (tracker.due_words.size() != 0)
			$display("ERROR: %0d expected words never arrived", tracker.due_words.size());
		if (tracker.mismatches == 0 && tracker.due_words.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
